// File: hw/rtl/bfbp_pkg.sv
package bfbp_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned BIN_INDEX_W   = 6;
  localparam int unsigned BINS_USED_W   = 7;
  localparam int unsigned DEF_MAX_BINS  = 64;
  localparam logic [WEIGHT_W-1:0] CAP_RESET = 16'd10;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_HEAVY  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DECIDE = 2'd2,
    S_OUT    = 2'd3
  } state_e;

  // Input word
  typedef struct packed {
    logic [WEIGHT_W-1:0] item_weight;
    logic                last_item;
  } item_t;

  // Output word
  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic                   opened_new;
    status_e                status;
    logic [BINS_USED_W-1:0] bins_used;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic scan_rd;
    logic decide;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/bfbp_ram.sv
module bfbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bfbp_ctrl.sv
module bfbp_ctrl
  import bfbp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        // last compare lands in the cycle scan_done first shows
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/bfbp_dpath.sv
module bfbp_dpath
  import bfbp_pkg::*;
#(
  parameter int unsigned MAX_BINS = DEF_MAX_BINS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  item_t               in_word_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output result_t             out_word_o
);

  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BINS);

  logic [WEIGHT_W-1:0] cap_q;
  item_t               item_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       addr_q;
  logic                rd_v_q;
  logic [AW-1:0]       cmp_idx_q;
  logic                found_q;
  logic [AW-1:0]       best_q;
  logic [WEIGHT_W-1:0] best_left_q;
  logic [WEIGHT_W-1:0] rdata;
  logic [WEIGHT_W-1:0] left;
  logic                fits;
  logic                take;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [WEIGHT_W-1:0] wdata;
  result_t             res_q, res_d;
  logic                out_valid_q;
  logic [31:0]         idx_ext;
  logic [31:0]         cnt_ext;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Held item word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
  end

  // Remaining space per bin
  bfbp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Scan address and read-valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.scan_rd;
      if (cmd_i.load_item) begin
        addr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        addr_q <= addr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      cmp_idx_q <= addr_q[AW-1:0];
    end
  end

  assign stat_o.scan_done = (addr_q >= count_q);

  // Best-fit compare on each returned entry; strict less keeps lowest index
  assign fits = (rdata >= item_q.item_weight);
  assign left = rdata - item_q.item_weight;
  assign take = rd_v_q && fits && (!found_q || (left < best_left_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q      <= cmp_idx_q;
      best_left_q <= left;
    end
  end

  // Placement decision, write-back and result
  always_comb begin
    we      = 1'b0;
    waddr   = best_q;
    wdata   = best_left_q;
    count_d = count_q;
    res_d   = '0;
    idx_ext = '0;
    if (item_q.item_weight > cap_q) begin
      res_d.status = ST_HEAVY;
    end else if (found_q) begin
      we           = cmd_i.decide;
      idx_ext      = 32'(best_q);
      res_d.status = ST_PLACED;
    end else if (count_q == CNT_FULL) begin
      res_d.status = ST_FULL;
    end else begin
      we               = cmd_i.decide;
      waddr            = count_q[AW-1:0];
      wdata            = cap_q - item_q.item_weight;
      idx_ext          = 32'(count_q);
      res_d.opened_new = 1'b1;
      res_d.status     = ST_PLACED;
      count_d          = count_q + CW'(1);
    end
    cnt_ext         = 32'(count_d);
    res_d.bin_index = idx_ext[BIN_INDEX_W-1:0];
    res_d.bins_used = cnt_ext[BINS_USED_W-1:0];
  end

  // Open bin count, cleared after a last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.decide) begin
      count_q <= item_q.last_item ? '0 : count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_q <= res_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_o <= res_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;

endmodule

// File: hw/rtl/best_fit_bin_packer_top.sv
// Best-fit bin packer. Each input word carries an item weight; the block
// scans the open bins in the bin table (one RAM read per open bin through
// the single read port of the bin table) and puts the item into the bin
// that leaves the least space, lowest index on a tie, or opens a new bin
// sized by the capacity register. With at most MAX_BINS bins open, each
// word goes through the states accept, scan, decide and write-back, then
// load of the output register, which waits while a held result is
// stalled; the block takes no new word until it is back in idle. A
// finished result sits in an output register so the next word can be
// accepted while it waits. Items heavier than the capacity, or needing a
// new bin when all MAX_BINS are open, report a status and are not placed.
// After a word with last_item set, all bins are closed. Write the
// capacity only while the block is idle.
module best_fit_bin_packer_top
  import bfbp_pkg::*;
#(
  parameter int unsigned MAX_BINS = DEF_MAX_BINS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  item_t               in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output result_t             out_word_o
);

  cmd_t  cmd;
  stat_t stat;

  bfbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfbp_dpath #(
    .MAX_BINS (MAX_BINS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: verif/best_fit_bin_packer_top_tb.sv
`timescale 1ns / 1ps

module best_fit_bin_packer_top_tb;
  import bfbp_pkg::*;

  localparam int unsigned MAX_WEIGHT = (1 << WEIGHT_W) - 1;
  // Worst case: scan of every bin plus decide and write-back, with margin
  localparam int unsigned SETTLE_CYCLES = DEF_MAX_BINS + 8;
  localparam int unsigned PHASE_WORDS = 70;
  localparam int unsigned NUM_PHASES = 8;

  // Tracks the bin table and holds the placements still to come out
  class bin_packing_tracker;
    logic [WEIGHT_W-1:0] capacity;
    logic [WEIGHT_W-1:0] space_left [DEF_MAX_BINS];
    int unsigned         open_bins;
    result_t             placement_q[$];
    int unsigned         mismatches;

    function new();
      capacity   = CAP_RESET;
      open_bins  = 0;
      mismatches = 0;
    endfunction

    // Best fit over the open bins; computes the placement for one word
    function void place_item(item_t it);
      bit                  found;
      int unsigned         best;
      logic [WEIGHT_W-1:0] best_left;
      logic [WEIGHT_W-1:0] left;
      result_t             r;
      found     = 1'b0;
      best      = 0;
      best_left = '0;
      for (int j = 0; j < open_bins; j++) begin
        if (space_left[j] >= it.item_weight) begin
          left = space_left[j] - it.item_weight;
          if (!found || left < best_left) begin
            found     = 1'b1;
            best      = j;
            best_left = left;
          end
        end
      end
      r.bin_index  = '0;
      r.opened_new = 1'b0;
      r.status     = ST_PLACED;
      if (it.item_weight > capacity) begin
        r.status = ST_HEAVY;
      end else if (found) begin
        space_left[best] = best_left;
        r.bin_index      = BIN_INDEX_W'(best);
      end else if (open_bins >= DEF_MAX_BINS) begin
        r.status = ST_FULL;
      end else begin
        space_left[open_bins] = capacity - it.item_weight;
        r.bin_index           = BIN_INDEX_W'(open_bins);
        r.opened_new          = 1'b1;
        open_bins++;
      end
      r.bins_used = BINS_USED_W'(open_bins);
      placement_q.push_back(r);
      // last word of a set closes every bin after its result
      if (it.last_item) open_bins = 0;
    endfunction

    // Compare one result word against the oldest placement
    function void check_result(result_t got);
      result_t want;
      if (placement_q.size() == 0) begin
        $error("result word with no placement pending: bin_index %0d", got.bin_index);
        mismatches++;
        return;
      end
      want = placement_q.pop_front();
      if (got.bin_index !== want.bin_index) begin
        $error("bin_index expected %0d actual %0d", want.bin_index, got.bin_index);
        mismatches++;
      end
      if (got.opened_new !== want.opened_new) begin
        $error("opened_new expected %0d actual %0d", want.opened_new, got.opened_new);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.bins_used !== want.bins_used) begin
        $error("bins_used expected %0d actual %0d", want.bins_used, got.bins_used);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [WEIGHT_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  item_t               in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  result_t             out_word_o;

  bin_packing_tracker tracker = new();
  bit                 calm    = 1'b0;

  best_fit_bin_packer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle on about 21 of 100 rolls, never during a calm stretch
  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 21);
  endfunction

  // Result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_word_o);
    out_stall_i <= idle_roll();
  end

  // Offer one word with random gaps ahead of it, return once accepted
  task automatic send_item(input logic [WEIGHT_W-1:0] weight, input logic last);
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{item_weight: weight, last_item: last};
    do @(posedge clk_i); while (in_stall_o);
    tracker.place_item('{item_weight: weight, last_item: last});
  endtask

  // Hold off the sender until every placement has come out
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (tracker.placement_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [WEIGHT_W-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.capacity = cap;
    @(posedge clk_i);
  endtask

  // Weight mix: heavy, full range, edges, small and fitting items
  function automatic logic [WEIGHT_W-1:0] pick_weight(input int unsigned cap);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10 && cap < MAX_WEIGHT) return WEIGHT_W'($urandom_range(MAX_WEIGHT, cap + 1));
    if (roll < 20) return WEIGHT_W'($urandom_range(MAX_WEIGHT, 0));
    if (roll < 28) return (roll % 2 == 0) ? WEIGHT_W'(cap) : '0;
    if (roll < 45) return WEIGHT_W'($urandom_range(cap / 4, 0));
    return WEIGHT_W'($urandom_range(cap, 0));
  endfunction

  initial begin
    int unsigned cap;
    int unsigned sent;
    int unsigned len;
    logic        last;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: exact fit, heavy words, best fit, tie to lowest bin
    send_item(16'd0, 1'b0);
    send_item(16'd10, 1'b0);
    send_item(16'd11, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd6, 1'b0);
    send_item(16'd6, 1'b0);
    send_item(16'd3, 1'b1);
    wait_for_results();

    // Zero capacity; a heavy last word still clears the table
    write_capacity(16'd0);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd0, 1'b1);
    wait_for_results();

    // Full-scale capacity and weights
    write_capacity(16'hFFFF);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'd1, 1'b1);
    wait_for_results();

    // Old bin larger than the new capacity: heavy word refused, small one fits there
    write_capacity(16'd1000);
    send_item(16'd100, 1'b0);
    wait_for_results();
    write_capacity(16'd5);
    send_item(16'd100, 1'b0);
    send_item(16'd3, 1'b1);

    // Random phases, each under its own capacity
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cap = 1;
        1: cap = MAX_WEIGHT;
        2: cap = 0;
        3: cap = 10;
        4: cap = $urandom_range(MAX_WEIGHT, 1);
        5: cap = $urandom_range(200, 2);
        6: cap = $urandom_range(20, 2);
        default: cap = 32768;
      endcase
      wait_for_results();
      write_capacity(WEIGHT_W'(cap));
      calm = (p == 3);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (cap >= 2 && $urandom_range(7) == 0) begin
          // Every word needs its own bin, so the table runs full
          len = $urandom_range(70, 66);
          for (int k = 0; k < len; k++)
            send_item(WEIGHT_W'($urandom_range(cap, cap / 2 + 1)), k == len - 1);
        end else begin
          len = $urandom_range(12, 1);
          for (int k = 0; k < len; k++) begin
            // most sets close on their last word; a few stray marks break sets
            if (k == len - 1) last = ($urandom_range(9) != 0);
            else last = ($urandom_range(29) == 0);
            send_item(pick_weight(cap), last);
          end
        end
        sent += len;
      end
    end
    calm = 1'b0;

    wait_for_results();
    if (tracker.mismatches == 0 && tracker.placement_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bfbp_pkg.sv
hw/rtl/bfbp_ram.sv
hw/rtl/bfbp_ctrl.sv
hw/rtl/bfbp_dpath.sv
hw/rtl/best_fit_bin_packer_top.sv
verif/best_fit_bin_packer_top_tb.sv
